[design/asc_pkg.sv]
`default_nettype none

package asc_pkg;

    // readings averaged per sample
    localparam int GRP_SIZE = 4;

    localparam int IN_W    = 16;
    localparam int SUM_W   = 18;
    localparam int SPAN_W  = 17;
    localparam int CNT_W   = 24;
    localparam int GRP_W   = 2;
    localparam int THR_W   = 16;
    localparam int LEN_W   = 8;
    localparam int IDX_W   = 2;

    // divide by GRP_SIZE as multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT = 20;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** DIV_SHIFT + GRP_SIZE - 1) / GRP_SIZE);
    localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(GRP_SIZE - 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [THR_W-1:0] DYN_THR_RST = 16'd30;
    localparam logic [THR_W-1:0] ACT_THR_RST = 16'd60;
    localparam logic [LEN_W-1:0] WIN_LEN_RST = 8'd50;

    typedef enum logic [IDX_W-1:0] {
        REG_DYN_THR = 2'd0,
        REG_ACT_THR = 2'd1,
        REG_WIN_LEN = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } t_axis;

    typedef logic signed [IN_W-1:0] t_s16;

    typedef struct packed {
        logic upd;
        logic bnd;
        logic start;
    } t_win_ctl;

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic [IN_W-1:0]   sold;
        logic [IN_W-1:0]   snew;
        logic [IN_W-1:0]   mid;
    } t_axis_stat;

    // signed sum divided by the group size, truncated toward zero
    function automatic t_s16 f_div_cnt(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0]         mag;
        logic [SUM_W+RECIP_W-1:0] prod;
        logic [IN_W-1:0]          q;
        mag  = s[SUM_W-1] ? (~s + 1'b1) : s;
        prod = (SUM_W+RECIP_W)'(mag) * (SUM_W+RECIP_W)'(RECIP);
        q    = prod[DIV_SHIFT +: IN_W];
        return s[SUM_W-1] ? t_s16'(~q + 1'b1) : t_s16'(q);
    endfunction

endpackage

`default_nettype wire

[design/asc_avg.sv]
`default_nettype none

module asc_avg
    import asc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_accel_x,
    input  wire logic [15:0] i_accel_y,
    input  wire logic [15:0] i_accel_z,
    input  wire logic        i_take,
    output logic             o_smp_valid,
    output t_s16             o_smp [3]
);

    logic [SUM_W-1:0] r_sum [3];
    logic [SUM_W-1:0] n_sum [3];
    logic [GRP_W-1:0] r_grp;
    logic             r_smp_valid;
    t_s16             r_smp [3];
    logic [IN_W-1:0]  w_in [3];
    logic             w_acc;
    logic             w_last;

    assign w_in[0] = i_accel_x;
    assign w_in[1] = i_accel_y;
    assign w_in[2] = i_accel_z;

    assign o_ready     = !r_smp_valid || i_take;
    assign w_acc       = i_valid && o_ready;
    assign w_last      = (r_grp == GRP_LAST);
    assign o_smp_valid = r_smp_valid;
    assign o_smp       = r_smp;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = r_sum[k] + {{(SUM_W-IN_W){w_in[k][IN_W-1]}}, w_in[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp       <= '0;
            r_smp_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (w_acc && w_last) begin
                r_smp_valid <= 1'b1;
            end else if (i_take) begin
                r_smp_valid <= 1'b0;
            end
            if (w_acc) begin
                if (w_last) begin
                    r_grp <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= '0;
                    end
                end else begin
                    r_grp <= r_grp + 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= n_sum[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_last) begin
            for (int k = 0; k < 3; k++) begin
                r_smp[k] <= f_div_cnt(n_sum[k]);
            end
        end
    end

endmodule

`default_nettype wire

[design/asc_axis.sv]
`default_nettype none

module asc_axis
    import asc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_win_ctl         i_ctl,
    input  wire logic [IN_W-1:0]  i_smp,
    input  wire logic [THR_W-1:0] i_dyn_thr,
    output t_axis_stat            o_stat
);

    logic [IN_W-1:0]   r_max, r_min, r_pmax, r_pmin, r_snew;
    logic [IN_W-1:0]   n_max, n_min, n_pmax, n_pmin, n_snew;
    logic [SPAN_W-1:0] w_diff;
    logic [SPAN_W-1:0] w_dmag;
    logic [SPAN_W-1:0] w_msum;
    logic [SPAN_W-1:0] w_madj;

    always_comb begin
        n_pmax = i_ctl.bnd ? r_max : r_pmax;
        n_pmin = i_ctl.bnd ? r_min : r_pmin;
        if (i_ctl.start) begin
            n_max = i_smp;
            n_min = i_smp;
        end else begin
            n_max = ($signed(i_smp) > $signed(r_max)) ? i_smp : r_max;
            n_min = ($signed(i_smp) < $signed(r_min)) ? i_smp : r_min;
        end

        w_diff = {i_smp[IN_W-1], i_smp} - {r_snew[IN_W-1], r_snew};
        w_dmag = w_diff[SPAN_W-1] ? (~w_diff + 1'b1) : w_diff;
        n_snew = (w_dmag > {1'b0, i_dyn_thr}) ? i_smp : r_snew;

        // midpoint of the previous window, rounded toward zero
        w_msum = {n_pmax[IN_W-1], n_pmax} + {n_pmin[IN_W-1], n_pmin};
        w_madj = w_msum + {{(SPAN_W-1){1'b0}}, w_msum[SPAN_W-1]};

        o_stat.span = {n_max[IN_W-1], n_max} - {n_min[IN_W-1], n_min};
        o_stat.sold = r_snew;
        o_stat.snew = n_snew;
        o_stat.mid  = w_madj[SPAN_W-1:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= '0;
            r_min  <= '0;
            r_pmax <= '0;
            r_pmin <= '0;
            r_snew <= '0;
        end else if (i_ctl.upd) begin
            r_max  <= n_max;
            r_min  <= n_min;
            r_pmax <= n_pmax;
            r_pmin <= n_pmin;
            r_snew <= n_snew;
        end
    end

endmodule

`default_nettype wire

[design/accel_step_counter_top.sv]
`default_nettype none

// Three-axis step counter. Every input transaction is one raw signed reading;
// each group of four readings is averaged (truncated toward zero) into one
// sample, and each sample yields one result transaction with the saturating
// step total, a step flag and the dominant axis (0 none, 1 x, 2 y, 3 z).
// The block takes one reading per cycle unless a finished sample waits on a
// full result register that is not taken: the accumulator with its divider
// feeds a sample register, and the combinational window, slide and axis logic
// feeds the result register. Configuration writes are taken at any time but
// should only be issued while no group is in progress or result pending.
module accel_step_counter_top
    import asc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_accel_x,
    input  wire logic [15:0] i_accel_y,
    input  wire logic [15:0] i_accel_z,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [23:0]      o_step_total,
    output logic             o_step_seen,
    output logic [1:0]       o_chosen_axis,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    logic [THR_W-1:0] r_dyn_thr;
    logic [THR_W-1:0] r_act_thr;
    logic [LEN_W-1:0] r_win_len;
    logic [LEN_W-1:0] r_wpos;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             r_step;
    t_axis            r_axis;
    t_axis            n_axis;
    logic             n_step;

    logic             w_smp_valid;
    t_s16             w_smp [3];
    logic             w_fire;
    t_win_ctl         w_ctl;
    t_axis_stat       w_stat [3];
    t_axis_stat       w_sel;
    logic [LEN_W:0]   w_pos;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] n_wpos;
    logic [2:0]       w_big;

    assign w_fire = w_smp_valid && (!r_out_valid || i_out_ready);

    asc_avg u_avg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_take      (w_fire),
        .o_smp_valid (w_smp_valid),
        .o_smp       (w_smp)
    );

    // window position; a zero length acts as one
    always_comb begin
        w_len  = (r_win_len == '0) ? LEN_W'(1) : r_win_len;
        w_pos  = {1'b0, r_wpos} + 1'b1;
        w_ctl.upd   = w_fire;
        w_ctl.bnd   = (w_pos > {1'b0, w_len});
        n_wpos      = w_ctl.bnd ? LEN_W'(1) : w_pos[LEN_W-1:0];
        w_ctl.start = (n_wpos == LEN_W'(1));
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        asc_axis u_axis (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_smp     (w_smp[g]),
            .i_dyn_thr (r_dyn_thr),
            .o_stat    (w_stat[g])
        );
        assign w_big[g] = (w_stat[g].span > w_stat[(g+1)%3].span)
                       && (w_stat[g].span > w_stat[(g+2)%3].span)
                       && (w_stat[g].span >= {1'b0, r_act_thr});
    end

    // dominant axis must be strictly the widest and active
    always_comb begin
        if (w_big[0]) begin
            n_axis = AXIS_X;
            w_sel  = w_stat[0];
        end else if (w_big[1]) begin
            n_axis = AXIS_Y;
            w_sel  = w_stat[1];
        end else if (w_big[2]) begin
            n_axis = AXIS_Z;
            w_sel  = w_stat[2];
        end else begin
            n_axis = AXIS_NONE;
            w_sel  = w_stat[0];
        end
        n_step = (n_axis != AXIS_NONE)
              && ($signed(w_sel.sold) > $signed(w_sel.mid))
              && ($signed(w_sel.snew) < $signed(w_sel.mid));
        n_cnt  = (n_step && (r_cnt != CNT_MAX)) ? (r_cnt + 1'b1) : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn_thr <= DYN_THR_RST;
            r_act_thr <= ACT_THR_RST;
            r_win_len <= WIN_LEN_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DYN_THR: r_dyn_thr <= i_cfg_data;
                REG_ACT_THR: r_act_thr <= i_cfg_data;
                REG_WIN_LEN: r_win_len <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_wpos      <= n_wpos;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_step <= n_step;
            r_axis <= n_axis;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_total  = r_cnt;
    assign o_step_seen   = r_step;
    assign o_chosen_axis = r_axis;

`ifndef SYNTH
    a_step_has_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_step_seen) |-> (o_chosen_axis != AXIS_NONE))
        else $error("step reported without a dominant axis");

    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_cnt >= $past(r_cnt)))
        else $error("step total went down");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_smp_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room downstream");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed sample produced no result");
`endif

endmodule

`default_nettype wire

[verif/accel_step_checker.sv]
module accel_step_checker
    import asc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [15:0] i_accel_x,
    input  wire logic [15:0] i_accel_y,
    input  wire logic [15:0] i_accel_z,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [23:0] i_step_total,
    input  wire logic        i_step_seen,
    input  wire logic [1:0]  i_chosen_axis,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct {
        logic [CNT_W-1:0] total;
        logic             seen;
        t_axis            axis;
    } t_step_report;

    t_step_report expected_reports[$];

    // register copies
    int dyn_thr;
    int act_thr;
    int win_len;

    // pedometer state
    int grp_sum[3];
    int grp_cnt;
    int win_hi[3];
    int win_lo[3];
    int last_hi[3];
    int last_lo[3];
    int track_new[3];
    int track_old[3];
    int win_pos;
    int step_cnt;

    int fails = 0;

    task automatic clear_model();
        int k;
        dyn_thr = int'(DYN_THR_RST);
        act_thr = int'(ACT_THR_RST);
        win_len = int'(WIN_LEN_RST);
        for (k = 0; k < 3; k++) begin
            grp_sum[k]   = 0;
            win_hi[k]    = 0;
            win_lo[k]    = 0;
            last_hi[k]   = 0;
            last_lo[k]   = 0;
            track_new[k] = 0;
            track_old[k] = 0;
        end
        grp_cnt  = 0;
        win_pos  = 0;
        step_cnt = 0;
        expected_reports.delete();
    endtask

    // one raw reading; every GRP_SIZE readings give one averaged sample
    task automatic take_reading(input t_s16 rx, input t_s16 ry, input t_s16 rz);
        int           smp[3];
        int           span[3];
        int           len;
        int           d;
        int           mid;
        int           ai;
        int           k;
        t_axis        pick;
        logic         hit;
        t_step_report rep;
        grp_sum[0] += rx;
        grp_sum[1] += ry;
        grp_sum[2] += rz;
        if (grp_cnt + 1 < GRP_SIZE) begin
            grp_cnt++;
            return;
        end
        grp_cnt = 0;
        for (k = 0; k < 3; k++) begin
            smp[k]     = grp_sum[k] / GRP_SIZE;
            grp_sum[k] = 0;
        end

        len = (win_len == 0) ? 1 : win_len;
        win_pos++;
        if (win_pos > len) begin
            win_pos = 1;
            last_hi = win_hi;
            last_lo = win_lo;
        end

        for (k = 0; k < 3; k++) begin
            if (win_pos == 1) begin
                win_hi[k] = smp[k];
                win_lo[k] = smp[k];
            end else begin
                if (smp[k] > win_hi[k]) win_hi[k] = smp[k];
                if (smp[k] < win_lo[k]) win_lo[k] = smp[k];
            end
            d = smp[k] - track_new[k];
            if (d < 0) d = -d;
            track_old[k] = track_new[k];
            if (d > dyn_thr) track_new[k] = smp[k];
            span[k] = win_hi[k] - win_lo[k];
        end

        // only a strictly largest span that is also wide enough wins
        pick = AXIS_NONE;
        ai   = 0;
        if (span[0] > span[1] && span[0] > span[2] && span[0] >= act_thr) begin
            pick = AXIS_X;
            ai   = 0;
        end else if (span[1] > span[0] && span[1] > span[2] && span[1] >= act_thr) begin
            pick = AXIS_Y;
            ai   = 1;
        end else if (span[2] > span[0] && span[2] > span[1] && span[2] >= act_thr) begin
            pick = AXIS_Z;
            ai   = 2;
        end

        hit = 1'b0;
        if (pick != AXIS_NONE) begin
            mid = (last_hi[ai] + last_lo[ai]) / 2;
            if (track_old[ai] > mid && track_new[ai] < mid) begin
                hit = 1'b1;
                if (step_cnt < CNT_MAX) step_cnt++;
            end
        end

        rep.total = CNT_W'(step_cnt);
        rep.seen  = hit;
        rep.axis  = pick;
        expected_reports.push_back(rep);
    endtask

    always @(posedge i_clk) begin
        t_step_report rep;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DYN_THR: dyn_thr = int'(i_cfg_data);
                    REG_ACT_THR: act_thr = int'(i_cfg_data);
                    REG_WIN_LEN: win_len = int'(i_cfg_data[LEN_W-1:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result transaction: step_total %0d step_seen %0d axis %0d",
                           i_step_total, i_step_seen, i_chosen_axis);
                    fails++;
                end else begin
                    rep = expected_reports.pop_front();
                    if (i_step_total !== rep.total) begin
                        $error("step_total: expected %0d, actual %0d", rep.total, i_step_total);
                        fails++;
                    end
                    if (i_step_seen !== rep.seen) begin
                        $error("step_seen: expected %0d, actual %0d", rep.seen, i_step_seen);
                        fails++;
                    end
                    if (i_chosen_axis !== rep.axis) begin
                        $error("chosen_axis: expected %0d, actual %0d", rep.axis, i_chosen_axis);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_reading(t_s16'(i_accel_x), t_s16'(i_accel_y), t_s16'(i_accel_z));
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fails;
    end

endmodule

[verif/accel_step_counter_top_test.sv]
module accel_step_counter_top_test;
    import asc_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_SAMPLES  = 24;
    localparam int READING_TARGET = 1000;
    localparam int STEADY_PHASE   = 5;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    t_s16        accel_x     = '0;
    t_s16        accel_y     = '0;
    t_s16        accel_z     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [23:0] step_total;
    logic        step_seen;
    logic [1:0]  chosen_axis;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_idx     = REG_DYN_THR;
    logic [15:0] cfg_data    = '0;

    int fail_count;
    int pending;
    bit steady        = 1'b0;
    int readings_sent = 0;
    int reports_seen  = 0;
    int steps_seen    = 0;
    int settings_used = 1;
    int quiet         = 0;

    accel_step_counter_top u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_accel_x     (accel_x),
        .i_accel_y     (accel_y),
        .i_accel_z     (accel_z),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_step_total  (step_total),
        .o_step_seen   (step_seen),
        .o_chosen_axis (chosen_axis),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    accel_step_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_accel_x     (accel_x),
        .i_accel_y     (accel_y),
        .i_accel_z     (accel_z),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_step_total  (step_total),
        .i_step_seen   (step_seen),
        .i_chosen_axis (chosen_axis),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        if (steady) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 32);
        end
    end

    // watchdog and result tally
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            reports_seen <= reports_seen + 1;
            steps_seen   <= steps_seen + int'(step_seen);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic t_s16 clamp16(input int v);
        if (v > 32767) return t_s16'(16'h7FFF);
        if (v < -32768) return t_s16'(16'h8000);
        return t_s16'(v);
    endfunction

    function automatic int tri_wave(input int i, input int per, input int amp);
        int d;
        d = 2 * (i % per) - per;
        if (d < 0) d = -d;
        return (2 * amp * d) / per - amp;
    endfunction

    task automatic send_reading(input t_s16 x, input t_s16 y, input t_s16 z);
        while (!steady && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        readings_sent++;
    endtask

    // one averaged sample: a full group of readings scattered around a level
    task automatic send_sample(input int sx, input int sy, input int sz, input int jit);
        int k;
        for (k = 0; k < GRP_SIZE; k++) begin
            send_reading(clamp16(sx + int'($urandom_range(2 * jit)) - jit),
                         clamp16(sy + int'($urandom_range(2 * jit)) - jit),
                         clamp16(sz + int'($urandom_range(2 * jit)) - jit));
        end
    endtask

    task automatic send_noise_sample();
        int k;
        for (k = 0; k < GRP_SIZE; k++) begin
            send_reading(t_s16'($urandom), t_s16'($urandom), t_s16'($urandom));
        end
    endtask

    // walking motion: one axis swings widely, the others wobble a little, with an occasional noise sample
    task automatic run_gait(input int n);
        int lead;
        int amp;
        int per;
        int minor_amp;
        int minor_per;
        int jit;
        int i;
        int k;
        int base[3];
        int v[3];
        lead      = $urandom_range(2);
        amp       = $urandom_range(200, 20000);
        per       = $urandom_range(3, 24);
        minor_amp = $urandom_range(amp / 4);
        minor_per = $urandom_range(3, 30);
        jit       = $urandom_range(50);
        for (k = 0; k < 3; k++) base[k] = int'($urandom_range(16000)) - 8000;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                send_noise_sample();
            end else begin
                for (k = 0; k < 3; k++) begin
                    v[k] = base[k] + ((k == lead) ? tri_wave(i, per, amp)
                                                  : tri_wave(i + k, minor_per, minor_amp));
                end
                send_sample(v[0], v[1], v[2], jit);
            end
        end
    endtask

    // hold the sender until the block has drained
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] dyn, input logic [15:0] act,
                                  input logic [15:0] len);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_DYN_THR;
        cfg_data <= dyn;
        @(posedge clk);
        cfg_idx  <= REG_ACT_THR;
        cfg_data <= act;
        @(posedge clk);
        cfg_idx  <= REG_WIN_LEN;
        cfg_data <= len;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int phase;
        int dyn;
        int act;
        int len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale readings on reset settings, then a tie between x and y
        send_sample(32767, 32767, 32767, 0);
        send_sample(-32768, -32768, 32767, 0);
        // small sums of mixed sign, averages truncate toward zero
        send_reading(-16'sd1, 16'sd1, -16'sd3);
        send_reading(16'sd0, 16'sd1, -16'sd2);
        send_reading(16'sd0, 16'sd1, -16'sd1);
        send_reading(16'sd0, 16'sd0, -16'sd1);

        // two-sample windows: rise then fall through the midpoint on x
        write_settings(16'd0, 16'd0, 16'd2);
        send_sample(0, 0, 0, 0);
        send_sample(1000, 0, 0, 0);
        send_sample(2000, 0, 0, 0);
        send_sample(-1000, 0, 0, 0);

        phase = 0;
        while (readings_sent < READING_TARGET) begin
            case (phase)
                0: begin
                    dyn = 65535; act = 65535; len = 255;
                end
                1: begin
                    dyn = 0; act = 0; len = 0;
                end
                2: begin
                    dyn = 0; act = 65535; len = 1;
                end
                3: begin
                    dyn = 65535; act = 0; len = ($urandom_range(255) << 8) | 255;
                end
                default: begin
                    dyn = $urandom_range(300);
                    act = $urandom_range(3000);
                    len = ($urandom_range(255) << 8) | $urandom_range(2, 16);
                end
            endcase
            write_settings(16'(dyn), 16'(act), 16'(len));
            steady <= (phase == STEADY_PHASE);
            if ($urandom_range(3) == 0) begin
                repeat (PHASE_SAMPLES) send_noise_sample();
            end else begin
                run_gait(PHASE_SAMPLES);
            end
            phase++;
        end
        steady <= 1'b0;

        settle();
        $display("sent %0d readings under %0d register settings", readings_sent, settings_used);
        $display("checked %0d result transactions, %0d of them with a step", reports_seen,
                 steps_seen);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
design/asc_pkg.sv
design/asc_avg.sv
design/asc_axis.sv
design/accel_step_counter_top.sv
verif/accel_step_checker.sv
verif/accel_step_counter_top_test.sv
